// File: hw/rtl/mlr_pkg.sv
// Shared constants, types and helpers for the midpoint line rasterizer.
package mlr_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	typedef enum logic [2:0] {
		ZONE_0 = 3'd0,
		ZONE_1 = 3'd1,
		ZONE_2 = 3'd2,
		ZONE_3 = 3'd3,
		ZONE_4 = 3'd4,
		ZONE_5 = 3'd5,
		ZONE_6 = 3'd6,
		ZONE_7 = 3'd7
	} zone_t;

	// Queue entry: opcode, zone, a0, b0, a1, minor delta, diagonal step,
	// initial decision value.
	function automatic int entry_width(input int coord_bits);
		return 4 + 5 * (coord_bits + 1) + coord_bits + 3;
	endfunction

endpackage

// File: hw/rtl/mlr_front.sv
// Front end: accept transactions, find the zone and map a new line into zone 0.
module mlr_front
	import mlr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic signed [COORD_BITS-1:0]        start_x,
	input  logic signed [COORD_BITS-1:0]        start_y,
	input  logic signed [COORD_BITS-1:0]        end_x,
	input  logic signed [COORD_BITS-1:0]        end_y,
	input  logic                                full,
	output logic                                push,
	output logic [entry_width(COORD_BITS)-1:0]  push_data
);

	localparam int CW = COORD_BITS + 1;
	localparam int DW = COORD_BITS + 3;

	logic signed [CW-1:0] dx_a, dy_a;
	logic        [CW-1:0] adx_a, ady_a;

	logic                 valid_s1;
	logic                 opcode_s1;
	logic signed [COORD_BITS-1:0] x0_s1, y0_s1, x1_s1, y1_s1;
	logic signed [CW-1:0] dx_s1, dy_s1;
	logic        [CW-1:0] adx_s1, ady_s1;

	logic                 dx_nonneg, dy_nonneg, dx_nonpos, dy_nonpos;
	logic                 x_gt_y, x_lt_y, major_is_x;
	zone_t                zone;
	logic signed [CW-1:0] x0e, y0e, x1e, y1e;
	logic signed [CW-1:0] a0, b0, a1;
	logic signed [CW-1:0] major_d, minor_d, diag;
	logic signed [DW-1:0] dec_init;

	// Deltas and magnitudes
	assign dx_a  = CW'(end_x) - CW'(start_x);
	assign dy_a  = CW'(end_y) - CW'(start_y);
	assign adx_a = dx_a[CW-1] ? -dx_a : dx_a;
	assign ady_a = dy_a[CW-1] ? -dy_a : dy_a;

	assign in_ready = !valid_s1 || !full;
	assign push     = valid_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			x0_s1     <= start_x;
			y0_s1     <= start_y;
			x1_s1     <= end_x;
			y1_s1     <= end_y;
			dx_s1     <= dx_a;
			dy_s1     <= dy_a;
			adx_s1    <= adx_a;
			ady_s1    <= ady_a;
		end
	end

	// Zone choice, tested in order
	assign dx_nonneg = !dx_s1[CW-1];
	assign dy_nonneg = !dy_s1[CW-1];
	assign dx_nonpos = dx_s1[CW-1] || (dx_s1 == '0);
	assign dy_nonpos = dy_s1[CW-1] || (dy_s1 == '0);
	assign x_gt_y    = adx_s1 > ady_s1;
	assign x_lt_y    = adx_s1 < ady_s1;

	always_comb begin
		if (dx_nonneg && dy_nonneg) begin
			zone = x_gt_y ? ZONE_0 : ZONE_1;
		end else if (dx_nonpos && dy_nonneg) begin
			zone = x_lt_y ? ZONE_2 : ZONE_3;
		end else if (dx_nonpos && dy_nonpos) begin
			zone = x_gt_y ? ZONE_4 : ZONE_5;
		end else begin
			zone = x_lt_y ? ZONE_6 : ZONE_7;
		end
	end

	assign x0e = CW'(x0_s1);
	assign y0e = CW'(y0_s1);
	assign x1e = CW'(x1_s1);
	assign y1e = CW'(y1_s1);

	// Map the start point and the end point's major coordinate into zone 0
	always_comb begin
		unique case (zone)
			ZONE_0: begin a0 = x0e;  b0 = y0e;  a1 = x1e;  end
			ZONE_1: begin a0 = y0e;  b0 = x0e;  a1 = y1e;  end
			ZONE_2: begin a0 = y0e;  b0 = -x0e; a1 = y1e;  end
			ZONE_3: begin a0 = -x0e; b0 = y0e;  a1 = -x1e; end
			ZONE_4: begin a0 = -x0e; b0 = -y0e; a1 = -x1e; end
			ZONE_5: begin a0 = -y0e; b0 = -x0e; a1 = -y1e; end
			ZONE_6: begin a0 = -y0e; b0 = x0e;  a1 = -y1e; end
			ZONE_7: begin a0 = x0e;  b0 = -y0e; a1 = x1e;  end
			default: begin a0 = x0e; b0 = y0e;  a1 = x1e;  end
		endcase
	end

	always_comb begin
		unique case (zone) inside
			ZONE_0, ZONE_3, ZONE_4, ZONE_7: major_is_x = 1'b1;
			default:                        major_is_x = 1'b0;
		endcase
	end

	// Zone-0 deltas are the magnitudes, the major one on the walked axis
	assign major_d  = major_is_x ? adx_s1 : ady_s1;
	assign minor_d  = major_is_x ? ady_s1 : adx_s1;
	assign diag     = minor_d - major_d;
	assign dec_init = DW'(minor_d) - DW'(major_d >>> 1);

	assign push_data = {opcode_s1, zone, a0, b0, a1, minor_d, diag, dec_init};

endmodule

// File: hw/rtl/mlr_queue.sv
// Small FIFO between the classifying front end and the walking back end.
module mlr_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              not_empty
);

	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]   count_q;

	assign full      = count_q == CNTW'(DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

// File: hw/rtl/mlr_back.sv
// Back end: hold the line state, walk the major axis, register each pixel.
module mlr_back
	import mlr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_not_empty,
	input  logic [entry_width(COORD_BITS)-1:0] q_data,
	output logic                               pop,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               pixel_valid,
	output logic signed [COORD_BITS-1:0]       pixel_x,
	output logic signed [COORD_BITS-1:0]       pixel_y,
	output logic                               last_pixel
);

	localparam int CW = COORD_BITS + 1;
	localparam int DW = COORD_BITS + 3;

	logic                 e_op;
	logic [2:0]           e_zone_bits;
	logic signed [CW-1:0] e_a0, e_b0, e_a1, e_minor, e_diag;
	logic signed [DW-1:0] e_dec;

	logic                 active_q;
	zone_t                zone_q;
	logic signed [CW-1:0] major_q, minor_q, end_q, minor_d_q, diag_q;
	logic signed [DW-1:0] dec_q;

	logic                 out_valid_q, pixel_valid_q, last_pixel_q;
	logic signed [COORD_BITS-1:0] pixel_x_q, pixel_y_q;

	logic                 is_start;
	logic signed [CW-1:0] next_major, cur_major, cur_minor;
	logic signed [CW-1:0] map_x, map_y;
	zone_t                cur_zone;
	logic                 cur_last, cur_valid;

	assign {e_op, e_zone_bits, e_a0, e_b0, e_a1, e_minor, e_diag, e_dec} = q_data;

	assign pop      = q_not_empty && (!out_valid_q || out_ready);
	assign is_start = e_op == OP_START;

	assign next_major = major_q + CW'(1);

	always_comb begin
		if (is_start) begin
			cur_zone  = zone_t'(e_zone_bits);
			cur_major = e_a0;
			cur_minor = e_b0;
			cur_last  = e_a0 >= e_a1;
			cur_valid = 1'b1;
		end else begin
			cur_zone  = zone_q;
			cur_major = next_major;
			cur_minor = dec_q[DW-1] ? minor_q : minor_q + CW'(1);
			cur_last  = next_major >= end_q;
			cur_valid = active_q;
		end
	end

	// Map the zone-0 point back to the original frame
	always_comb begin
		unique case (cur_zone)
			ZONE_0: begin map_x = cur_major;  map_y = cur_minor;  end
			ZONE_1: begin map_x = cur_minor;  map_y = cur_major;  end
			ZONE_2: begin map_x = -cur_minor; map_y = cur_major;  end
			ZONE_3: begin map_x = -cur_major; map_y = cur_minor;  end
			ZONE_4: begin map_x = -cur_major; map_y = -cur_minor; end
			ZONE_5: begin map_x = -cur_minor; map_y = -cur_major; end
			ZONE_6: begin map_x = cur_minor;  map_y = -cur_major; end
			ZONE_7: begin map_x = cur_major;  map_y = -cur_minor; end
			default: begin map_x = cur_major; map_y = cur_minor;  end
		endcase
	end

	// Line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (pop && (is_start || active_q)) begin
			active_q <= !cur_last;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (is_start) begin
				zone_q    <= zone_t'(e_zone_bits);
				major_q   <= e_a0;
				minor_q   <= e_b0;
				end_q     <= e_a1;
				minor_d_q <= e_minor;
				diag_q    <= e_diag;
				dec_q     <= e_dec;
			end else if (active_q) begin
				major_q <= next_major;
				minor_q <= cur_minor;
				dec_q   <= dec_q + (dec_q[DW-1] ? DW'(minor_d_q) : DW'(diag_q));
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pixel_valid_q <= cur_valid;
			pixel_x_q     <= cur_valid ? map_x[COORD_BITS-1:0] : '0;
			pixel_y_q     <= cur_valid ? map_y[COORD_BITS-1:0] : '0;
			last_pixel_q  <= cur_valid && cur_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_valid = pixel_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign last_pixel  = last_pixel_q;

endmodule

// File: hw/rtl/midpoint_line_rasterizer_core.sv
// Top level of the midpoint line rasterizer: front end, queue and back end.
//
// Usage: every input transaction on in_valid/in_ready carries an opcode.
// A start transaction (with both endpoints) loads a new line and yields its
// first pixel; a step transaction yields the next pixel of the current line.
// Every input transaction yields exactly one output transaction on
// out_valid/out_ready: pixel_valid, pixel_x, pixel_y and last_pixel, the
// last flag set on the line's second endpoint. A step with no line loaded
// returns pixel_valid = 0 and zero coordinates. A start drops any old line.
// Path: each input transaction passes the front stage register, which
// finds the zone and deltas, the queue, and the output register, into
// which the back end walks a pixel. Throughput: one transaction per
// clock while out_ready stays high; the back end does one add and
// compare per pixel, and the front end classifies one item per clock.
// When the receiver stalls, the output register holds its transaction, the
// queue fills and in_ready drops only once the queue and front stage are
// full. Reset (arst_n low) empties the queue and pipeline, drops the active
// line and clears out_valid.
module midpoint_line_rasterizer_core
	import mlr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         pixel_valid,
	output logic signed [COORD_BITS-1:0] pixel_x,
	output logic signed [COORD_BITS-1:0] pixel_y,
	output logic                         last_pixel
);

	localparam int ENTRY_W = entry_width(COORD_BITS);

	logic               q_full, q_push, q_pop, q_not_empty;
	logic [ENTRY_W-1:0] q_push_data, q_pop_data;

	// Classify each transaction and map new lines into zone 0
	mlr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.full      (q_full),
		.push      (q_push),
		.push_data (q_push_data)
	);

	// Decouple the two halves so each can stall on its own
	mlr_queue #(
		.DATA_W (ENTRY_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.not_empty (q_not_empty)
	);

	// Walk the line and drive the output transaction
	mlr_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (q_pop_data),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_valid (pixel_valid),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.last_pixel  (last_pixel)
	);

endmodule

// File: tb/sv/midpoint_line_rasterizer_checker.sv
`timescale 1ns / 1ps
// Pixel stream checker for the midpoint line rasterizer: predicts each pixel and compares.
module midpoint_line_rasterizer_checker
	import mlr_pkg::*;
#(
	parameter int CB = COORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 opcode,
	input  logic signed [CB-1:0] start_x,
	input  logic signed [CB-1:0] start_y,
	input  logic signed [CB-1:0] end_x,
	input  logic signed [CB-1:0] end_y,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 pixel_valid,
	input  logic signed [CB-1:0] pixel_x,
	input  logic signed [CB-1:0] pixel_y,
	input  logic                 last_pixel,
	output int                   fail_count,
	output int                   pending,
	output int                   line_starts,
	output int                   pixels_seen,
	output int                   idle_steps,
	output int                   lines_ended,
	output logic [7:0]           zones_seen
);

	typedef logic signed [CB:0]   coord_w_t;
	typedef logic signed [CB+2:0] decision_t;

	typedef struct packed {
		logic          valid;
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic          last;
	} pixel_t;

	// Local copy of the line walker state
	logic      line_live;
	zone_t     line_zone;
	coord_w_t  pos_major;
	coord_w_t  pos_minor;
	coord_w_t  major_stop;
	coord_w_t  span_major;
	coord_w_t  span_minor;
	decision_t midpoint_err;

	pixel_t pixels_due[$];
	int     reported;

	initial begin
		fail_count  = 0;
		pending     = 0;
		line_starts = 0;
		pixels_seen = 0;
		idle_steps  = 0;
		lines_ended = 0;
		zones_seen  = '0;
		reported    = 0;
	end

	function automatic void into_zone0(input zone_t z, input coord_w_t x, input coord_w_t y,
			output coord_w_t a, output coord_w_t b);
		case (z)
			ZONE_0: begin a = x;  b = y;  end
			ZONE_1: begin a = y;  b = x;  end
			ZONE_2: begin a = y;  b = -x; end
			ZONE_3: begin a = -x; b = y;  end
			ZONE_4: begin a = -x; b = -y; end
			ZONE_5: begin a = -y; b = -x; end
			ZONE_6: begin a = -y; b = x;  end
			default: begin a = x; b = -y; end
		endcase
	endfunction

	function automatic void from_zone0(input zone_t z, input coord_w_t a, input coord_w_t b,
			output coord_w_t x, output coord_w_t y);
		case (z)
			ZONE_0: begin x = a;  y = b;  end
			ZONE_1: begin x = b;  y = a;  end
			ZONE_2: begin x = -b; y = a;  end
			ZONE_3: begin x = -a; y = b;  end
			ZONE_4: begin x = -a; y = -b; end
			ZONE_5: begin x = -b; y = -a; end
			ZONE_6: begin x = b;  y = -a; end
			default: begin x = a; y = -b; end
		endcase
	endfunction

	// Advance the walker by one input transaction and return the pixel it produces.
	function automatic pixel_t rasterize_item(input logic op,
			input logic signed [CB-1:0] sx, input logic signed [CB-1:0] sy,
			input logic signed [CB-1:0] ex, input logic signed [CB-1:0] ey);
		coord_w_t  x0, y0, x1, y1, a1, b1, dx, dy, ax, ay, px, py;
		decision_t half;
		logic      at_end;
		if (op == OP_START) begin
			x0 = coord_w_t'(sx);
			y0 = coord_w_t'(sy);
			x1 = coord_w_t'(ex);
			y1 = coord_w_t'(ey);
			dx = x1 - x0;
			dy = y1 - y0;
			ax = (dx < 0) ? -dx : dx;
			ay = (dy < 0) ? -dy : dy;
			if (dx >= 0 && dy >= 0)
				line_zone = (ax > ay) ? ZONE_0 : ZONE_1;
			else if (dx <= 0 && dy >= 0)
				line_zone = (ax < ay) ? ZONE_2 : ZONE_3;
			else if (dx <= 0 && dy <= 0)
				line_zone = (ax > ay) ? ZONE_4 : ZONE_5;
			else
				line_zone = (ax < ay) ? ZONE_6 : ZONE_7;
			into_zone0(line_zone, x0, y0, pos_major, pos_minor);
			into_zone0(line_zone, x1, y1, a1, b1);
			major_stop   = a1;
			span_major   = a1 - pos_major;
			span_minor   = b1 - pos_minor;
			// major span is never negative, so the shift is the halving
			half         = decision_t'(span_major >>> 1);
			midpoint_err = decision_t'(span_minor) - half;
			zones_seen[line_zone] = 1'b1;
		end else if (!line_live) begin
			return '0;
		end else begin
			pos_major = pos_major + coord_w_t'(1);
			if (midpoint_err < 0) begin
				midpoint_err = midpoint_err + decision_t'(span_minor);
			end else begin
				midpoint_err = midpoint_err + decision_t'(span_minor)
					- decision_t'(span_major);
				pos_minor    = pos_minor + coord_w_t'(1);
			end
		end
		at_end    = (pos_major >= major_stop);
		line_live = !at_end;
		from_zone0(line_zone, pos_major, pos_minor, px, py);
		return '{1'b1, px[CB-1:0], py[CB-1:0], at_end};
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		pixel_t got;
		pixel_t want;
		pixel_t due;
		if (!arst_n) begin
			line_live    = 1'b0;
			line_zone    = ZONE_0;
			pos_major    = '0;
			pos_minor    = '0;
			major_stop   = '0;
			span_major   = '0;
			span_minor   = '0;
			midpoint_err = '0;
			pixels_due.delete();
			pending      = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{pixel_valid, pixel_x, pixel_y, last_pixel};
				if (pixel_valid === 1'b1)
					pixels_seen++;
				else
					idle_steps++;
				if (last_pixel === 1'b1)
					lines_ended++;
				if (pixels_due.size() == 0) begin
					fail_count++;
					if (reported < 10)
						$display("%0t: output transaction with nothing outstanding", $realtime);
					reported++;
				end else begin
					want = pixels_due.pop_front();
					if (got !== want) begin
						fail_count++;
						if (reported < 10)
							$display({"%0t: pixel mismatch: expected valid=%b x=%0d y=%0d last=%b,",
								" got valid=%b x=%0d y=%0d last=%b"}, $realtime,
								want.valid, $signed(want.x), $signed(want.y), want.last,
								got.valid, $signed(got.x), $signed(got.y), got.last);
						reported++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (opcode == OP_START)
					line_starts++;
				due        = rasterize_item(opcode, start_x, start_y, end_x, end_y);
				pixels_due = {pixels_due, due};
			end
			pending = pixels_due.size();
		end
	end

endmodule

// File: tb/sv/midpoint_line_rasterizer_core_test.sv
`timescale 1ns / 1ps
// Testbench top for the midpoint line rasterizer: stimulus, handshakes and verdict.
module midpoint_line_rasterizer_core_test;
	import mlr_pkg::*;

	localparam int CB             = COORD_BITS_DEF;
	localparam int COORD_MIN      = -(1 << (CB - 1));
	localparam int COORD_MAX      = (1 << (CB - 1)) - 1;
	localparam int TOTAL_ITEMS    = 620;
	localparam int HOLD_AT        = 220;
	localparam int PAUSE_AT       = 400;
	localparam int CALM_FROM      = 460;
	localparam int CALM_TO        = 540;
	localparam int RX_HOLD_CYCLES = 120;
	localparam int STALL_LIMIT    = 1000;
	localparam int SETTLE_CYCLES  = 10;

	// Every input of the block starts at a known value
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 opcode    = OP_START;
	logic signed [CB-1:0] start_x   = '0;
	logic signed [CB-1:0] start_y   = '0;
	logic signed [CB-1:0] end_x     = '0;
	logic signed [CB-1:0] end_y     = '0;
	logic                 out_ready = 1'b0;

	logic                 in_ready;
	logic                 out_valid;
	logic                 pixel_valid;
	logic signed [CB-1:0] pixel_x;
	logic signed [CB-1:0] pixel_y;
	logic                 last_pixel;

	int         fail_count;
	int         pending;
	int         line_starts;
	int         pixels_seen;
	int         idle_steps;
	int         lines_ended;
	logic [7:0] zones_seen;

	int items_sent = 0;
	bit hold_rx    = 1'b0;  // ask the receiver for one long hold-off
	bit calm       = 1'b0;  // no idling on either side while set

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	midpoint_line_rasterizer_core #(
		.COORD_BITS(CB)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_valid(pixel_valid),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last_pixel (last_pixel)
	);

	midpoint_line_rasterizer_checker #(
		.CB(CB)
	) pixel_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_valid(pixel_valid),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last_pixel (last_pixel),
		.fail_count (fail_count),
		.pending    (pending),
		.line_starts(line_starts),
		.pixels_seen(pixels_seen),
		.idle_steps (idle_steps),
		.lines_ended(lines_ended),
		.zones_seen (zones_seen)
	);

	// Idle length for either side: mostly none, often short, now and then a long one.
	function automatic int pick_gap();
		int p;
		if (calm)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Full-range coordinate, with the two extremes drawn more often than chance.
	function automatic int rand_coord();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
		return int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
	endfunction

	function automatic int clamp_coord(input int v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	// Offer one transaction from the falling edge, hold it until accepted,
	// then optionally drop valid for a random idle stretch.
	task automatic send_item(input logic op, input int sx, input int sy, input int ex,
			input int ey);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		opcode   <= op;
		start_x  <= sx[CB-1:0];
		start_y  <= sy[CB-1:0];
		end_x    <= ex[CB-1:0];
		end_y    <= ey[CB-1:0];
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Step payload is ignored by the block, so fill it with noise.
	task automatic send_step();
		send_item(OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
	endtask

	task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
			input int steps);
		send_item(OP_START, sx, sy, ex, ey);
		repeat (steps) send_step();
	endtask

	// Stimulus: reset, directed corner cases, then random line walks.
	initial begin : stimulus
		int  sx, sy, ex, ey, dx, dy, r, kind, shape, span, steps;
		bit  held;
		bit  paused;
		held   = 1'b0;
		paused = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Step with no line loaded right out of reset
		send_step();
		// Single-point lines at both corners; the step after the first must be idle
		draw_line(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1);
		draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
		// Full-range diagonal and anti-diagonal, each dropped by the next start
		draw_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 2);
		draw_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1);
		// Shallow line walked to its end, then one step past it
		draw_line(0, 0, 3, 1, 4);
		// Horizontal leftward and vertical downward lines, walked to the end
		draw_line(5, 0, 2, 0, 3);
		draw_line(0, 0, 0, -2, 2);
		// Steep line hugging the left and top edges
		draw_line(COORD_MIN, COORD_MAX, COORD_MIN + 2, COORD_MAX - 7, 1);

		while (items_sent < TOTAL_ITEMS) begin
			// Long receiver hold-off: keep offering so the block fills and stalls input
			if (!held && items_sent >= HOLD_AT) begin
				hold_rx = 1'b1;
				held    = 1'b1;
			end
			// Sender pause until every outstanding pixel has come back
			if (!paused && items_sent >= PAUSE_AT) begin
				@(negedge clk) in_valid <= 1'b0;
				while (pending != 0)
					@(negedge clk);
				paused = 1'b1;
			end
			calm = (items_sent >= CALM_FROM && items_sent < CALM_TO);

			kind = $urandom_range(0, 99);
			sx   = rand_coord();
			sy   = rand_coord();
			if (kind < 85) begin
				// Short line anywhere on the grid, mostly walked to the end
				r     = ($urandom_range(0, 9) == 0) ? 60 : 12;
				dx    = int'($urandom_range(0, 2 * r)) - r;
				dy    = int'($urandom_range(0, 2 * r)) - r;
				shape = $urandom_range(0, 9);
				if (shape == 0)
					dy = dx;
				else if (shape == 1)
					dy = -dx;
				else if (shape == 2)
					dx = 0;
				else if (shape == 3)
					dy = 0;
				ex   = clamp_coord(sx + dx);
				ey   = clamp_coord(sy + dy);
				dx   = (ex > sx) ? ex - sx : sx - ex;
				dy   = (ey > sy) ? ey - sy : sy - ey;
				span = (dx > dy) ? dx : dy;
				if (kind < 70)
					steps = span + (($urandom_range(0, 3) == 0) ? 1 : 0);
				else
					steps = $urandom_range(0, span);
				draw_line(sx, sy, ex, ey, steps);
			end else if (kind < 95) begin
				// Long line with random endpoints, abandoned after a few pixels
				draw_line(sx, sy, rand_coord(), rand_coord(), $urandom_range(0, 8));
			end else begin
				// Stray steps, mostly landing on an idle block
				repeat ($urandom_range(1, 3)) send_step();
			end
		end
		calm = 1'b0;

		@(negedge clk) in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		// Let anything extra the block might emit show up at the checker
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Sent %0d input transactions: %0d line starts, %0d pixels, %0d idle steps.",
			items_sent, line_starts, pixels_seen, idle_steps);
		$display("Lines ended: %0d; zones reached (one bit per zone): %b.",
			lines_ended, zones_seen);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Receiver: random ready pattern, one long counted hold-off on request,
	// and a stretch of steady ready while calm is set.
	initial begin : receiver
		int run;
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_rx) begin
				@(negedge clk) out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
				hold_rx = 1'b0;
			end else if (calm) begin
				@(negedge clk) out_ready <= 1'b1;
			end else begin
				run = $urandom_range(1, 12);
				repeat (run) @(negedge clk) out_ready <= 1'b1;
				gap = pick_gap();
				repeat (gap) @(negedge clk) out_ready <= 1'b0;
			end
		end
	end

	// Watchdog: end the run if no transaction moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles, %0d pixels outstanding",
					quiet, pending);
				$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule

// File: midpoint_line_rasterizer_core.f
hw/rtl/mlr_pkg.sv
hw/rtl/mlr_front.sv
hw/rtl/mlr_queue.sv
hw/rtl/mlr_back.sv
hw/rtl/midpoint_line_rasterizer_core.sv
tb/sv/midpoint_line_rasterizer_checker.sv
tb/sv/midpoint_line_rasterizer_core_test.sv
